// ===== sv/lcdmtc_pkg.sv =====
package lcdmtc_pkg;

  // Lengths of the scan modes and of a whole line.
  localparam logic [9:0] LEN_OAM    = 10'd80;
  localparam logic [9:0] LEN_XFER   = 10'd172;
  localparam logic [9:0] LEN_HBLANK = 10'd204;
  localparam logic [9:0] LEN_LINE   = 10'd456;

  localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [7:0] LINES_PER_FRAME   = 8'd154;

  // Reciprocal of the OAM length, scaled by 2**14; exact for sums below 640.
  localparam logic [7:0] OAM_RECIP       = 8'd205;
  localparam int         OAM_RECIP_SHIFT = 14;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_LCD_ENABLE   = 2'd0,
    CFG_STAT_IRQ_EN  = 2'd1,
    CFG_LINE_COMPARE = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        lcd_enable;
    logic [3:0]  irq_en;
    logic [7:0]  line_compare;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  cycle;
    logic [7:0]  line;
    mode_e       mode;
    logic        match;
  } ctr_t;

  typedef struct packed {
    logic [7:0]  line;
    mode_e       mode;
    logic [6:0]  status;
    logic        vblank_irq;
    logic        stat_irq;
    logic        render_line;
  } res_t;

endpackage

// ===== sv/lcdmtc_step.sv =====
module lcdmtc_step (
  input  lcdmtc_pkg::cfg_t  cfg_i,
  input  lcdmtc_pkg::ctr_t  cur_i,
  input  logic [5:0]        elapsed_cycles_i,
  output lcdmtc_pkg::ctr_t  nxt_o,
  output lcdmtc_pkg::res_t  res_o
);

  logic [9:0]  sum;
  logic [17:0] oam_prod;
  logic [2:0]  oam_quo;
  logic [9:0]  oam_rem;
  logic [7:0]  line_inc;
  logic        vbl;
  logic        sirq;
  logic        rend;

  assign sum      = cur_i.cycle + {4'd0, elapsed_cycles_i};
  assign oam_prod = {8'd0, sum} * {10'd0, lcdmtc_pkg::OAM_RECIP};
  assign oam_quo  = oam_prod[lcdmtc_pkg::OAM_RECIP_SHIFT +: 3];
  assign oam_rem  = sum - 10'({7'd0, oam_quo} * lcdmtc_pkg::LEN_OAM);
  assign line_inc = cur_i.line + 8'd1;

  always_comb begin
    nxt_o = cur_i;
    vbl   = 1'b0;
    sirq  = 1'b0;
    rend  = 1'b0;
    if (!cfg_i.lcd_enable) begin
      nxt_o.cycle = '0;
      nxt_o.line  = '0;
      nxt_o.mode  = lcdmtc_pkg::MODE_HBLANK;
    end else begin
      nxt_o.match = (cur_i.line == cfg_i.line_compare);
      sirq        = nxt_o.match & cfg_i.irq_en[3];
      nxt_o.cycle = sum;
      unique case (cur_i.mode)
        lcdmtc_pkg::MODE_OAM: begin
          if (sum >= lcdmtc_pkg::LEN_OAM) begin
            nxt_o.cycle = oam_rem;
            nxt_o.mode  = lcdmtc_pkg::MODE_XFER;
          end
        end
        lcdmtc_pkg::MODE_XFER: begin
          if (sum >= lcdmtc_pkg::LEN_XFER) begin
            nxt_o.cycle = sum - lcdmtc_pkg::LEN_XFER;
            nxt_o.mode  = lcdmtc_pkg::MODE_HBLANK;
            rend        = 1'b1;
            sirq        = sirq | cfg_i.irq_en[0];
          end
        end
        lcdmtc_pkg::MODE_HBLANK: begin
          if (sum >= lcdmtc_pkg::LEN_HBLANK) begin
            nxt_o.cycle = sum - lcdmtc_pkg::LEN_HBLANK;
            nxt_o.line  = line_inc;
            if (line_inc == lcdmtc_pkg::FIRST_VBLANK_LINE) begin
              nxt_o.mode = lcdmtc_pkg::MODE_VBLANK;
              vbl        = 1'b1;
              sirq       = sirq | cfg_i.irq_en[1];
            end else begin
              nxt_o.mode = lcdmtc_pkg::MODE_OAM;
              sirq       = sirq | cfg_i.irq_en[2];
            end
          end
        end
        lcdmtc_pkg::MODE_VBLANK: begin
          if (sum >= lcdmtc_pkg::LEN_LINE) begin
            nxt_o.cycle = sum - lcdmtc_pkg::LEN_LINE;
            nxt_o.line  = line_inc;
            if (line_inc == lcdmtc_pkg::LINES_PER_FRAME) begin
              nxt_o.line = '0;
              nxt_o.mode = lcdmtc_pkg::MODE_OAM;
              sirq       = sirq | cfg_i.irq_en[2];
            end
          end
        end
      endcase
    end
  end

  // The status mode bits lag: they show the mode from before this step.
  assign res_o.line        = nxt_o.line;
  assign res_o.mode        = nxt_o.mode;
  assign res_o.status      = {cfg_i.irq_en, nxt_o.match, cur_i.mode};
  assign res_o.vblank_irq  = vbl;
  assign res_o.stat_irq    = sirq;
  assign res_o.render_line = rend;

endmodule

// ===== sv/lcd_mode_timing_controller_unit.sv =====
// Channel  Handshake                  Payload
// cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in_valid_i / in_ready_o    elapsed_cycles_i
// out      out_valid_o / out_ready_i  current_line_o, current_mode_o, status_byte_o,
//                                     vblank_irq_o, stat_irq_o, render_line_o
//
// Each tick is processed in the cycle it is accepted: the counters update and the
// result is captured in the output or skid register; one tick per cycle holds while
// results drain. A skid register behind the output register keeps taking a tick while
// a result waits; the input stalls only when both hold results.
// Reset clears the counters and puts the mode in OAM search; configuration resets
// to zero, with the display off. The configuration port is always ready.
module lcd_mode_timing_controller_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [5:0] elapsed_cycles_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] current_line_o,
  output logic [1:0] current_mode_o,
  output logic [6:0] status_byte_o,
  output logic       vblank_irq_o,
  output logic       stat_irq_o,
  output logic       render_line_o
);

  lcdmtc_pkg::cfg_t cfg_q;
  lcdmtc_pkg::ctr_t ctr_q;
  lcdmtc_pkg::ctr_t ctr_nxt;
  lcdmtc_pkg::res_t res_nxt;
  lcdmtc_pkg::res_t out_q, out_d;
  lcdmtc_pkg::res_t skid_q, skid_d;
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic             in_xfer;
  logic             out_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;

  // The whole tick update is one combinational pass over the counter state.
  lcdmtc_step u_step (
    .cfg_i            (cfg_q),
    .cur_i            (ctr_q),
    .elapsed_cycles_i (elapsed_cycles_i),
    .nxt_o            (ctr_nxt),
    .res_o            (res_nxt)
  );

  // Configuration writes; an index past the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (lcdmtc_pkg::cfg_idx_e'(cfg_index_i))
        lcdmtc_pkg::CFG_LCD_ENABLE:   cfg_q.lcd_enable   <= cfg_data_i[0];
        lcdmtc_pkg::CFG_STAT_IRQ_EN:  cfg_q.irq_en       <= cfg_data_i[3:0];
        lcdmtc_pkg::CFG_LINE_COMPARE: cfg_q.line_compare <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Counter state advances only on an input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q.cycle <= '0;
      ctr_q.line  <= '0;
      ctr_q.mode  <= lcdmtc_pkg::MODE_OAM;
      ctr_q.match <= 1'b0;
    end else if (in_xfer) begin
      ctr_q <= ctr_nxt;
    end
  end

  // Output register with a skid entry. The skid entry fills only when a new
  // result arrives while the output register holds one that is not taken.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_xfer) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (in_xfer) begin
        out_d = res_nxt;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_q) begin
        out_d       = res_nxt;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_nxt;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign current_line_o = out_q.line;
  assign current_mode_o = out_q.mode;
  assign status_byte_o  = out_q.status;
  assign vblank_irq_o   = out_q.vblank_irq;
  assign stat_irq_o     = out_q.stat_irq;
  assign render_line_o  = out_q.render_line;

`ifndef SYNTHESIS
  a_cycle_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_q.cycle < lcdmtc_pkg::LEN_LINE)
    else $error("cycle counter left its range");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register is empty");

  a_render_hblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.render_line |-> out_q.mode == lcdmtc_pkg::MODE_HBLANK)
    else $error("render strobe outside hblank entry");

  a_vblank_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.vblank_irq |->
      out_q.line == lcdmtc_pkg::FIRST_VBLANK_LINE)
    else $error("vblank pulse away from the first vblank line");

  a_in_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> skid_valid_q)
    else $error("pending result dropped");
`endif

endmodule

// ===== bench/tb_lcd_mode_timing_controller_unit.sv =====
`timescale 1ns / 100ps

module tb_lcd_mode_timing_controller_unit;

  // Each entry in the stimulus queue is either a tick with its elapsed cycle
  // count, or a register write that must wait until the block is idle.
  typedef struct {
    logic                  is_cfg;
    lcdmtc_pkg::cfg_idx_e  idx;
    logic [7:0]            data;
    logic [5:0]            cycles;
  } scan_op_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       cfg_valid_i      = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i      = 2'd0;
  logic [7:0] cfg_data_i       = 8'd0;
  logic       in_valid_i       = 1'b0;
  logic       in_ready_o;
  logic [5:0] elapsed_cycles_i = 6'd0;
  logic       out_valid_o;
  logic       out_ready_i      = 1'b0;
  logic [7:0] current_line_o;
  logic [1:0] current_mode_o;
  logic [6:0] status_byte_o;
  logic       vblank_irq_o;
  logic       stat_irq_o;
  logic       render_line_o;

  // Stimulus waiting for the driver and scan results waiting for the block.
  scan_op_t          pending_ops[$];
  lcdmtc_pkg::res_t  expected_scans[$];

  // Set by the sampling block at a rising edge when a transfer took place,
  // read by the driver at the following falling edge.
  bit tick_taken  = 1'b0;
  bit write_taken = 1'b0;

  int unsigned ticks_sent = 0;
  int unsigned mismatches = 0;

  // Independent copy of the display timing state and its registers.
  logic              disp_on     = 1'b0;
  logic [3:0]        irq_en      = 4'd0;
  logic [7:0]        ly_compare  = 8'd0;
  logic [9:0]        scan_cycle  = 10'd0;
  logic [7:0]        scan_line   = 8'd0;
  lcdmtc_pkg::mode_e scan_mode   = lcdmtc_pkg::MODE_OAM;
  logic [1:0]        lagged_mode = 2'd0;
  logic              match_q     = 1'b0;

  lcd_mode_timing_controller_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .elapsed_cycles_i (elapsed_cycles_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .current_line_o   (current_line_o),
    .current_mode_o   (current_mode_o),
    .status_byte_o    (status_byte_o),
    .vblank_irq_o     (vblank_irq_o),
    .stat_irq_o       (stat_irq_o),
    .render_line_o    (render_line_o)
  );

  always #1 clk_i = ~clk_i;

  // Advances the timing state by one tick and returns what the block should
  // report for it. The STAT mode bits always show the mode from before the
  // tick. With the display off the counters clear to line 0 in hblank while
  // the match flag keeps its last value.
  function automatic lcdmtc_pkg::res_t scan_step(input logic [5:0] dt);
    lcdmtc_pkg::res_t r;
    logic vbl;
    logic sirq;
    logic rend;
    vbl  = 1'b0;
    sirq = 1'b0;
    rend = 1'b0;
    lagged_mode = scan_mode;
    if (!disp_on) begin
      scan_cycle = '0;
      scan_line  = '0;
      scan_mode  = lcdmtc_pkg::MODE_HBLANK;
    end else begin
      // The compare uses the line from before the tick and fires the STAT
      // interrupt on every tick that matches, not just the first one.
      match_q = (scan_line == ly_compare);
      if (match_q && irq_en[3]) sirq = 1'b1;
      scan_cycle = scan_cycle + 10'(dt);
      // At most one mode change per tick; the counter keeps its remainder.
      case (scan_mode)
        lcdmtc_pkg::MODE_OAM: begin
          if (scan_cycle >= lcdmtc_pkg::LEN_OAM) begin
            scan_cycle = scan_cycle % lcdmtc_pkg::LEN_OAM;
            scan_mode  = lcdmtc_pkg::MODE_XFER;
          end
        end
        lcdmtc_pkg::MODE_XFER: begin
          if (scan_cycle >= lcdmtc_pkg::LEN_XFER) begin
            scan_cycle = scan_cycle % lcdmtc_pkg::LEN_XFER;
            scan_mode  = lcdmtc_pkg::MODE_HBLANK;
            rend       = 1'b1;
            if (irq_en[0]) sirq = 1'b1;
          end
        end
        lcdmtc_pkg::MODE_HBLANK: begin
          if (scan_cycle >= lcdmtc_pkg::LEN_HBLANK) begin
            scan_cycle = scan_cycle % lcdmtc_pkg::LEN_HBLANK;
            scan_line  = scan_line + 8'd1;
            if (scan_line == lcdmtc_pkg::FIRST_VBLANK_LINE) begin
              scan_mode = lcdmtc_pkg::MODE_VBLANK;
              vbl       = 1'b1;
              if (irq_en[1]) sirq = 1'b1;
            end else begin
              scan_mode = lcdmtc_pkg::MODE_OAM;
              if (irq_en[2]) sirq = 1'b1;
            end
          end
        end
        default: begin
          if (scan_cycle >= lcdmtc_pkg::LEN_LINE) begin
            scan_cycle = scan_cycle % lcdmtc_pkg::LEN_LINE;
            scan_line  = scan_line + 8'd1;
            if (scan_line == lcdmtc_pkg::LINES_PER_FRAME) begin
              scan_line = '0;
              scan_mode = lcdmtc_pkg::MODE_OAM;
              if (irq_en[2]) sirq = 1'b1;
            end
          end
        end
      endcase
    end
    r.line        = scan_line;
    r.mode        = scan_mode;
    r.status      = {irq_en, match_q, lagged_mode};
    r.vblank_irq  = vbl;
    r.stat_irq    = sirq;
    r.render_line = rend;
    return r;
  endfunction

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  task automatic add_tick(input logic [5:0] cycles);
    scan_op_t op;
    op.is_cfg = 1'b0;
    op.idx    = lcdmtc_pkg::CFG_UNUSED;
    op.data   = '0;
    op.cycles = cycles;
    pending_ops.push_back(op);
  endtask

  task automatic add_write(input lcdmtc_pkg::cfg_idx_e idx, input logic [7:0] data);
    scan_op_t op;
    op.is_cfg = 1'b1;
    op.idx    = idx;
    op.data   = data;
    op.cycles = '0;
    pending_ops.push_back(op);
  endtask

  // Random ticks. The fast mix keeps most ticks near the maximum to reach
  // vblank and the frame wrap; the rest are drawn from the full range so
  // every value still shows up.
  task automatic add_ticks(input int count, input bit fast);
    for (int i = 0; i < count; i++) begin
      if (fast && $urandom_range(0, 99) < 90) add_tick(6'($urandom_range(58, 63)));
      else add_tick(6'($urandom_range(0, 63)));
    end
  endtask

  // Register data with random bits above the field, which the block ignores.
  function automatic logic [7:0] enable_word(input bit on);
    return {7'($urandom), on};
  endfunction

  function automatic logic [7:0] irq_word(input logic [3:0] en);
    return {4'($urandom), en};
  endfunction

  // Sampling at the rising edge. Outputs are compared against the oldest
  // expectation first; the block registers its result, so a tick accepted at
  // this edge can never be the one reported at this same edge.
  always @(posedge clk_i) begin
    lcdmtc_pkg::res_t want;
    tick_taken  = 1'b0;
    write_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_scans.size() == 0) begin
          $display("%0t: result transfer with nothing expected, line %0d mode %0d",
                   $time, current_line_o, current_mode_o);
          mismatches++;
        end else begin
          want = expected_scans.pop_front();
          check_field("current_line", want.line, current_line_o);
          check_field("current_mode", want.mode, current_mode_o);
          check_field("status_byte", want.status, status_byte_o);
          check_field("vblank_irq", want.vblank_irq, vblank_irq_o);
          check_field("stat_irq", want.stat_irq, stat_irq_o);
          check_field("render_line", want.render_line, render_line_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_taken = 1'b1;
        case (lcdmtc_pkg::cfg_idx_e'(cfg_index_i))
          lcdmtc_pkg::CFG_LCD_ENABLE:   disp_on    = cfg_data_i[0];
          lcdmtc_pkg::CFG_STAT_IRQ_EN:  irq_en     = cfg_data_i[3:0];
          lcdmtc_pkg::CFG_LINE_COMPARE: ly_compare = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        tick_taken = 1'b1;
        expected_scans.push_back(scan_step(elapsed_cycles_i));
      end
    end
  end

  // Driver, working at the falling edge. A valid that has not been taken yet
  // is left alone. Register writes only go out once every expected result
  // has come back, which is the only time the block is known to be idle.
  // A window of ticks runs with neither side idling.
  always @(negedge clk_i) begin
    scan_op_t op;
    bit       calm;
    logic     next_tick_v;
    logic     next_write_v;
    if (rst_ni) begin
      calm = (ticks_sent >= 500 && ticks_sent < 800);
      out_ready_i <= calm || ($urandom_range(0, 99) >= 29);
      if (!((in_valid_i && !tick_taken) || (cfg_valid_i && !write_taken))) begin
        next_tick_v  = 1'b0;
        next_write_v = 1'b0;
        if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
          op = pending_ops[0];
          if (!op.is_cfg) begin
            void'(pending_ops.pop_front());
            next_tick_v = 1'b1;
            elapsed_cycles_i <= op.cycles;
            ticks_sent++;
          end else if (expected_scans.size() == 0) begin
            void'(pending_ops.pop_front());
            next_write_v = 1'b1;
            cfg_index_i <= op.idx;
            cfg_data_i  <= op.data;
          end
        end
        in_valid_i  <= next_tick_v;
        cfg_valid_i <= next_write_v;
      end
    end
  end

  initial begin
    logic [3:0] long_irq[5];

    // Display off straight out of reset: the first tick still shows the
    // reset mode (oam search) in the STAT mode bits.
    add_tick(6'd0);
    add_tick(6'd63);

    // Display on, every interrupt enabled and line 0 compared, so the match
    // interrupt repeats on every tick of line 0. The ticks start in hblank, where the
    // display-off tick left the counters, and walk into line 1 and its oam,
    // transfer and hblank, with leftover cycles carried across each mode change.
    add_write(lcdmtc_pkg::CFG_LCD_ENABLE, enable_word(1'b1));
    add_write(lcdmtc_pkg::CFG_STAT_IRQ_EN, irq_word(4'hF));
    add_write(lcdmtc_pkg::CFG_LINE_COMPARE, 8'd0);
    add_write(lcdmtc_pkg::CFG_UNUSED, 8'($urandom));
    add_tick(6'd63);
    add_tick(6'd63);
    add_tick(6'd0);
    add_tick(6'd63);
    add_tick(6'd63);
    add_tick(6'd63);
    add_tick(6'd63);
    add_tick(6'd63);
    add_tick(6'd63);
    add_tick(6'd1);
    add_tick(6'd62);
    add_tick(6'd42);

    // Display off in the middle of a line: the counters clear, the match
    // flag holds. Then back on with a compare value no line can reach.
    add_write(lcdmtc_pkg::CFG_LCD_ENABLE, enable_word(1'b0));
    add_tick(6'd5);
    add_write(lcdmtc_pkg::CFG_LCD_ENABLE, enable_word(1'b1));
    add_write(lcdmtc_pkg::CFG_STAT_IRQ_EN, irq_word(4'h0));
    add_write(lcdmtc_pkg::CFG_LINE_COMPARE, 8'd255);
    add_tick(6'd63);
    add_tick(6'd63);

    // Short random phases over the first lines.
    add_write(lcdmtc_pkg::CFG_STAT_IRQ_EN, irq_word(4'($urandom)));
    add_write(lcdmtc_pkg::CFG_LINE_COMPARE, 8'($urandom_range(0, 3)));
    add_ticks(40, 1'b0);
    add_write(lcdmtc_pkg::CFG_LCD_ENABLE, enable_word(1'b0));
    add_ticks(20, 1'b0);
    add_write(lcdmtc_pkg::CFG_LCD_ENABLE, enable_word(1'b1));
    add_write(lcdmtc_pkg::CFG_STAT_IRQ_EN, irq_word(4'b1000));
    add_write(lcdmtc_pkg::CFG_LINE_COMPARE, 8'd1);
    add_ticks(40, 1'b0);

    // One long run from line 0 through vblank and past the frame wrap. The
    // display is toggled off first to restart the frame. The registers change
    // between stretches while the display stays on; the last stretch watches
    // line 153 with everything enabled.
    long_irq[0] = 4'hF;
    long_irq[1] = 4'b0001;
    long_irq[2] = 4'b0110;
    long_irq[3] = 4'($urandom);
    long_irq[4] = 4'hF;
    add_write(lcdmtc_pkg::CFG_LCD_ENABLE, enable_word(1'b0));
    add_tick(6'($urandom));
    add_write(lcdmtc_pkg::CFG_LCD_ENABLE, enable_word(1'b1));
    for (int s = 0; s < 5; s++) begin
      add_write(lcdmtc_pkg::CFG_STAT_IRQ_EN, irq_word(long_irq[s]));
      add_write(lcdmtc_pkg::CFG_LINE_COMPARE,
                (s == 4) ? 8'd153 : 8'($urandom_range(0, 143)));
      add_ticks(260, 1'b1);
    end

    // Reset is held low from time zero and released at a falling edge.
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the driver to drain and every expected result to arrive, then
    // keep watching the output stage for any stray transfer.
    while (pending_ops.size() != 0 || in_valid_i || cfg_valid_i ||
           expected_scans.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("lcd_mode_timing_controller_unit regression: pass");
    end else begin
      $display("lcd_mode_timing_controller_unit regression: fail");
    end
    $finish;
  end

  // Watchdog. A correct run finishes well before it fires.
  initial begin
    #200000;
    $display("lcd_mode_timing_controller_unit regression: fail");
    $finish;
  end

endmodule
